@@ rtl/core/circular_queue_with_dump_assert.svh @@
// Assertion helpers for the queue RTL
`ifndef CIRCULAR_QUEUE_WITH_DUMP_ASSERT_SVH
`define CIRCULAR_QUEUE_WITH_DUMP_ASSERT_SVH

// same-cycle implication, idle during reset
`define CQD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, idle during reset
`define CQD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/cqd_pkg.sv @@
package cqd_pkg;

	// action codes (s_tuser)
	localparam logic [1:0] ACT_ENQ  = 2'd0;
	localparam logic [1:0] ACT_DEQ  = 2'd1;
	localparam logic [1:0] ACT_DUMP = 2'd2;

	// status codes (m_tuser)
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned CAP_W  = 6;

	// control sequencer
	typedef enum logic [1:0] {
		S_IDLE   = 2'b01,
		S_STREAM = 2'b10
	} cqd_state_t;

endpackage

@@ rtl/core/cqd_ram.sv @@
// Simple dual-port RAM, one write port, one registered read port
module cqd_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/circular_queue_with_dump.sv @@
// Ring-buffer FIFO of 32-bit words with a dump command. The ring has capacity+1
// slots with one always spare, so it holds up to capacity words (capacity is
// clamped to 1..SLOTS-1; writing it empties the queue). An enqueue's result is
// loaded straight into the output register; a dequeue's word comes out of the
// synchronous RAM the cycle after its read; a dump delivers one word per cycle
// through the single RAM read port when the output side does not stall. A new
// item is taken only once the block is idle, no capacity write is offered, and
// its output register is free or being drained. Every command gives one result
// (last set) except a non-empty dump, which gives one per held word, oldest
// first, with last on the newest. Action 3 is taken and dropped.
`include "circular_queue_with_dump_assert.svh"

module circular_queue_with_dump
	import cqd_pkg::*;
#(
	parameter int unsigned SLOTS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration write: capacity
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CAP_W-1:0]  cfg_data,
	// input items
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [WORD_W-1:0] s_tdata,   // [31:0] push_value
	input  logic [1:0]        s_tuser,   // [1:0] action
	// result items
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [WORD_W-1:0] m_tdata,   // [31:0] word_out
	output logic [1:0]        m_tuser,   // [1:0] status
	output logic              m_tlast
);

	localparam int unsigned PW = $clog2(SLOTS);
	localparam logic [PW-1:0] LIM_MAX = PW'(SLOTS - 1);

	// clamp a capacity write to 1..SLOTS-1
	function automatic logic [PW-1:0] clamp_cap(input logic [CAP_W-1:0] c);
		logic [CAP_W:0] c_ext;
		logic [PW-1:0]  r;
		c_ext = {1'b0, c};
		if (c == '0) begin
			r = PW'(1);
		end else if (c_ext > (CAP_W+1)'(SLOTS - 1)) begin
			r = LIM_MAX;
		end else begin
			r = c[PW-1:0];
		end
		return r;
	endfunction

	// step around a ring whose last index is lim
	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] i, input logic [PW-1:0] lim);
		logic [PW-1:0] r;
		if (i == lim) begin
			r = '0;
		end else begin
			r = i + PW'(1);
		end
		return r;
	endfunction

	cqd_state_t     state_q;
	logic [PW-1:0]  lim_q, head_q, tail_q, p_q;
	logic           pend_q, pend_last_q, more_q;
	logic           m_tvalid_q, m_tlast_q;
	logic [1:0]     m_tuser_q;
	logic [WORD_W-1:0] m_tdata_q;

	logic              acc, out_free, move, issue, empty, full;
	logic [PW-1:0]     nt_tail, nh, np;
	logic              ram_we, ram_re;
	logic [PW-1:0]     ram_raddr;
	logic [WORD_W-1:0] rd_data;
	logic              ld, ld_last;
	logic [1:0]        ld_stat;
	logic [WORD_W-1:0] ld_word;

	assign out_free  = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE) && out_free && !cfg_valid;
	assign cfg_ready = (state_q == S_IDLE);
	assign acc       = s_tvalid && s_tready;

	assign nt_tail = nxt(tail_q, lim_q);
	assign nh      = nxt(head_q, lim_q);
	assign np      = nxt(p_q, lim_q);
	assign empty   = (head_q == tail_q);
	assign full    = (nt_tail == head_q);

	// streaming: pending RAM word moves out, next read issues behind it
	assign move  = pend_q && out_free;
	assign issue = (state_q == S_STREAM) && more_q && (!pend_q || move);

	// memory port control
	assign ram_we    = acc && (s_tuser == ACT_ENQ) && !full;
	assign ram_re    = (acc && (s_tuser inside {ACT_DEQ, ACT_DUMP}) && !empty) || issue;
	assign ram_raddr = acc ? nh : np;

	cqd_ram #(
		.WIDTH (WORD_W),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (nt_tail),
		.wdata (s_tdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	// output register load select
	always_comb begin
		ld      = 1'b0;
		ld_stat = STAT_OK;
		ld_word = '0;
		ld_last = 1'b1;
		if (move) begin
			ld      = 1'b1;
			ld_word = rd_data;
			ld_last = pend_last_q;
		end else if (acc) begin
			case (s_tuser)
				ACT_ENQ: begin
					ld      = 1'b1;
					ld_stat = full ? STAT_FULL : STAT_OK;
				end
				ACT_DEQ, ACT_DUMP: begin
					ld      = empty;
					ld_stat = STAT_EMPTY;
				end
				default: begin
					ld = 1'b0;
				end
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			lim_q      <= clamp_cap(CAP_W'(63));
			head_q     <= '0;
			tail_q     <= '0;
			p_q        <= '0;
			pend_q     <= 1'b0;
			more_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (ld) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			if (cfg_valid && cfg_ready) begin
				lim_q  <= clamp_cap(cfg_data);
				head_q <= '0;
				tail_q <= '0;
			end else if (acc) begin
				case (s_tuser)
					ACT_ENQ: begin
						if (!full) begin
							tail_q <= nt_tail;
						end
					end
					ACT_DEQ: begin
						if (!empty) begin
							head_q  <= nh;
							pend_q  <= 1'b1;
							more_q  <= 1'b0;
							state_q <= S_STREAM;
						end
					end
					ACT_DUMP: begin
						if (!empty) begin
							p_q     <= nh;
							pend_q  <= 1'b1;
							more_q  <= (nh != tail_q);
							state_q <= S_STREAM;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end else if (state_q == S_STREAM) begin
				if (issue) begin
					p_q    <= np;
					pend_q <= 1'b1;
					more_q <= (np != tail_q);
				end else if (move) begin
					pend_q <= 1'b0;
				end
				if (move && pend_last_q) begin
					state_q <= S_IDLE;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ld) begin
			m_tuser_q <= ld_stat;
			m_tdata_q <= ld_word;
			m_tlast_q <= ld_last;
		end
		if (acc) begin
			pend_last_q <= (s_tuser == ACT_DEQ) || (nh == tail_q);
		end else if (issue) begin
			pend_last_q <= (np == tail_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	`CQD_ASSERT_IMPL(a_ptr_in_ring, 1'b1, (head_q <= lim_q) && (tail_q <= lim_q), "pointer outside ring")
	`CQD_ASSERT_NEXT(a_pend_hold, pend_q && !out_free, pend_q && $stable(rd_data), "stalled word lost")
	`CQD_ASSERT_IMPL(a_idle_quiet, state_q == S_IDLE, !pend_q && !more_q, "read pending while idle")
	`CQD_ASSERT_IMPL(a_mid_dump, m_tvalid && !m_tlast, state_q == S_STREAM, "dump ended before last")

endmodule

@@ tb/cqd_queue_monitor.sv @@
// Watches the config, input and result channels of the queue, keeps its own
// copy of the ring and checks every result item against it in order.
module cqd_queue_monitor
	import cqd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [CAP_W-1:0]  cfg_data,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [WORD_W-1:0] s_tdata,   // [31:0] push_value
	input  logic [1:0]        s_tuser,   // [1:0] action
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [WORD_W-1:0] m_tdata,   // [31:0] word_out
	input  logic [1:0]        m_tuser,   // [1:0] status
	input  logic              m_tlast,
	output int unsigned       errors,
	output int unsigned       pending,
	output int unsigned       results_seen
);

	localparam int unsigned RING_MAX = 64;

	typedef struct packed {
		logic [1:0]        status;
		logic [WORD_W-1:0] word;
		logic              last;
	} queue_result_t;

	queue_result_t     due_results[$];
	logic [WORD_W-1:0] ring_words[RING_MAX];
	int unsigned       head_ptr;
	int unsigned       tail_ptr;
	int unsigned       ring_slots;
	int unsigned       err_cnt;
	int unsigned       seen_cnt;

	// pointer advance around a ring of capacity+1 slots
	function automatic int unsigned ring_next(input int unsigned p);
		return (p + 1) % ring_slots;
	endfunction

	function automatic void push_result(input logic [1:0] st, input logic [WORD_W-1:0] w,
			input logic lst);
		queue_result_t r;
		r.status = st;
		r.word   = w;
		r.last   = lst;
		due_results.push_back(r);
	endfunction

	// queue behavior for one command; pushes the result items it causes
	task automatic model_command(input logic [1:0] act, input logic [WORD_W-1:0] val);
		int unsigned p;
		int unsigned nt;
		case (act)
			ACT_ENQ: begin
				nt = ring_next(tail_ptr);
				if (nt == head_ptr) begin
					push_result(STAT_FULL, '0, 1'b1);
				end else begin
					tail_ptr = nt;
					ring_words[nt] = val;
					push_result(STAT_OK, '0, 1'b1);
				end
			end
			ACT_DEQ: begin
				if (head_ptr == tail_ptr) begin
					push_result(STAT_EMPTY, '0, 1'b1);
				end else begin
					head_ptr = ring_next(head_ptr);
					push_result(STAT_OK, ring_words[head_ptr], 1'b1);
				end
			end
			ACT_DUMP: begin
				p = head_ptr;
				if (p == tail_ptr) begin
					push_result(STAT_EMPTY, '0, 1'b1);
				end else begin
					while (p != tail_ptr) begin
						p = ring_next(p);
						push_result(STAT_OK, ring_words[p], p == tail_ptr);
					end
				end
			end
			default: ; // dropped by the block
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
			input logic [WORD_W-1:0] want);
		$display("ERROR @%0t result #%0d: %s got %h, want %h",
			$time, seen_cnt, what, got, want);
		err_cnt++;
	endtask

	// compare one accepted result item with the oldest expectation
	task automatic check_result();
		queue_result_t w;
		if (due_results.size() == 0) begin
			report_mismatch("unexpected result, word", m_tdata, '0);
		end else begin
			w = due_results.pop_front();
			if (m_tuser !== w.status)
				report_mismatch("status", WORD_W'(m_tuser), WORD_W'(w.status));
			if (m_tdata !== w.word)
				report_mismatch("word", m_tdata, w.word);
			if (m_tlast !== w.last)
				report_mismatch("last", WORD_W'(m_tlast), WORD_W'(w.last));
		end
		seen_cnt++;
	endtask

	initial begin
		err_cnt  = 0;
		seen_cnt = 0;
	end

	// channel watch: config, results, then new commands
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_results.delete();
			head_ptr   = 0;
			tail_ptr   = 0;
			ring_slots = 64;
			for (int i = 0; i < RING_MAX; i++)
				ring_words[i] = '0;
			errors       <= 0;
			pending      <= 0;
			results_seen <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				ring_slots = ((cfg_data == 0) ? 1 : int'(cfg_data)) + 1;
				head_ptr   = 0;
				tail_ptr   = 0;
			end
			if (m_tvalid && m_tready)
				check_result();
			if (s_tvalid && s_tready)
				model_command(s_tuser, s_tdata);
			errors       <= err_cnt;
			pending      <= due_results.size();
			results_seen <= seen_cnt;
		end
	end

endmodule

@@ tb/circular_queue_with_dump_tb.sv @@
// Stimulus and verdict for the ring-buffer queue; checking lives in the monitor.
module circular_queue_with_dump_tb
	import cqd_pkg::*;
();

	localparam logic [1:0] ACT_NOP = 2'd3;   // dropped by the block
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned SETTLE_CYCLES = 6;

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CAP_W-1:0]  cfg_data;
	logic              s_tvalid;
	logic              s_tready;
	logic [WORD_W-1:0] s_tdata;   // [31:0] push_value
	logic [1:0]        s_tuser;   // [1:0] action
	logic              m_tvalid;
	logic              m_tready;
	logic [WORD_W-1:0] m_tdata;   // [31:0] word_out
	logic [1:0]        m_tuser;   // [1:0] status
	logic              m_tlast;

	int unsigned errors;
	int unsigned pending;
	int unsigned results_seen;

	int unsigned src_idle_pct;
	int unsigned sink_idle_pct;
	bit          hold_req;
	int unsigned cmds_sent;
	int unsigned nops_sent;
	int unsigned cap_writes;

	circular_queue_with_dump u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	cqd_queue_monitor u_mon (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast),
		.errors       (errors),
		.pending      (pending),
		.results_seen (results_seen)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// offer one command and wait for it to be taken; random idle cycles after
	task automatic send_cmd(input logic [1:0] act, input logic [WORD_W-1:0] val);
		s_tuser  <= act;
		s_tdata  <= val;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (act == ACT_NOP)
			nops_sent++;
		else
			cmds_sent++;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// stop offering and wait until every expected result has come out
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		cfg_data  <= cap;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cap_writes++;
	endtask

	// mostly full-range random words, sometimes the corner values
	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(11))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	// random command mix; enq_pct biases enqueue against dequeue
	task automatic random_phase(input int unsigned count, input int unsigned enq_pct);
		int unsigned done;
		int unsigned r;
		logic [1:0]  act;
		done = 0;
		while (done < count) begin
			r = $urandom_range(99);
			if (r < 3)
				act = ACT_NOP;
			else if (r < 13)
				act = ACT_DUMP;
			else if ($urandom_range(99) < enq_pct)
				act = ACT_ENQ;
			else
				act = ACT_DEQ;
			send_cmd(act, pick_word());
			if (act != ACT_NOP)
				done++;
		end
	endtask

	// result side: random stalls, or a long hold-off when asked
	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	// run limit
	initial begin
		#20_000_000;
		$display("circular_queue_with_dump_tb failed");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = ACT_ENQ;
		hold_req      = 1'b0;
		src_idle_pct  = 21;
		sink_idle_pct = 21;
		cmds_sent     = 0;
		nops_sent     = 0;
		cap_writes    = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset capacity: empty cases, corner words, dropped action, dump order
		send_cmd(ACT_DUMP, 32'h0);
		send_cmd(ACT_DEQ, 32'hFFFF_FFFF);
		send_cmd(ACT_ENQ, 32'h7FFF_FFFF);
		send_cmd(ACT_ENQ, 32'h8000_0000);
		send_cmd(ACT_ENQ, 32'h0000_0000);
		send_cmd(ACT_ENQ, 32'hFFFF_FFFF);
		send_cmd(ACT_NOP, 32'h1234_5678);
		send_cmd(ACT_DUMP, 32'h0);
		send_cmd(ACT_DEQ, 32'h0);
		send_cmd(ACT_DEQ, 32'h0);
		send_cmd(ACT_ENQ, 32'h5A5A_A5A5);
		send_cmd(ACT_DUMP, 32'h0);
		repeat (4) send_cmd(ACT_DEQ, 32'h0);
		settle();

		// single-word queue: full on the second enqueue
		write_capacity(6'd1);
		send_cmd(ACT_ENQ, 32'hA5A5_5A5A);
		send_cmd(ACT_ENQ, 32'h0000_0001);
		send_cmd(ACT_DUMP, 32'h0);
		send_cmd(ACT_DEQ, 32'h0);
		send_cmd(ACT_DUMP, 32'h0);
		settle();

		// zero capacity behaves as one
		write_capacity(6'd0);
		send_cmd(ACT_ENQ, 32'hC3C3_3C3C);
		send_cmd(ACT_ENQ, 32'h0000_0002);
		send_cmd(ACT_DUMP, 32'h0);
		settle();

		// full size, no idling on either side
		write_capacity(6'd63);
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		random_phase(60, 70);
		src_idle_pct  = 21;
		sink_idle_pct = 21;

		// result side holds off while enqueue-heavy commands are offered, then drain
		hold_req = 1'b1;
		random_phase(80, 95);
		settle();
		random_phase(60, 20);
		settle();

		write_capacity(6'd3);
		random_phase(50, 55);
		settle();

		write_capacity(6'd0);
		random_phase(40, 55);
		settle();

		write_capacity(CAP_W'($urandom_range(62, 2)));
		random_phase(50, 60);
		settle();

		write_capacity(6'd1);
		random_phase(30, 50);
		settle();

		write_capacity(6'd63);
		random_phase(30, 50);
		settle();

		repeat (20) @(posedge clk);
		$display("run: %0d commands (+%0d dropped), %0d capacity writes, %0d results checked",
			cmds_sent, nops_sent, cap_writes, results_seen);
		$display("run: capacities 0, 1, 3, 63 and one random, with long output hold-off");
		if (errors == 0 && pending == 0)
			$display("circular_queue_with_dump_tb passed");
		else
			$display("circular_queue_with_dump_tb failed");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/cqd_pkg.sv
rtl/core/cqd_ram.sv
rtl/core/circular_queue_with_dump.sv
tb/cqd_queue_monitor.sv
tb/circular_queue_with_dump_tb.sv
